// File: design/max_balanced_checkerboard_rectangle_defines.svh
// Assertion helpers used by the main design file.
`ifndef MAX_BALANCED_CHECKERBOARD_RECTANGLE_DEFINES_SVH
`define MAX_BALANCED_CHECKERBOARD_RECTANGLE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MBCR_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MBCR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define MBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mbcr_pkg.sv
package mbcr_pkg;

    localparam int DEFAULT_MAX_DIM    = 64;
    localparam int DEFAULT_VALUE_BITS = 8;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_DIFF,
        ST_DIFF_END,
        ST_PAIR,
        ST_PAIR_END,
        ST_DONE
    } mbcr_state_t;

endpackage

// File: design/max_balanced_checkerboard_rectangle.sv
// Largest balanced checkerboard rectangle. Cells stream in row-major order over
// row_count x column_count (each clamped to 1..MAX_DIM; a zero acts as one).
// A cell with odd row+column counts as white (+value), the rest as black
// (-value); each accepted cell is taken in ST_IDLE and then written in ST_CELL,
// while a running row sum and one read of the row above extend a 2-D prefix
// table held in a single-write, dual-read RAM. Row 0 and column 0 of the
// table are an implicit zero border and are never stored, so no clearing pass
// is needed. After the last cell the block is busy with the search and takes
// no cells: for every row band (top, bottom) it first sweeps cols+1 columns to
// build the band's column differences in a small RAM, then walks every column
// pair through one shared compare-and-multiply unit, one pair per cycle. After
// the last band the result moves to the output register once that is free.
// One best_area transfer follows each complete grid. A register write drops a
// partial grid. The result sits in an output register, so the block returns to
// accepting cells while a result waits for m_ready.
`include "max_balanced_checkerboard_rectangle_defines.svh"

module max_balanced_checkerboard_rectangle #(
    parameter int MAX_DIM    = mbcr_pkg::DEFAULT_MAX_DIM,
    parameter int VALUE_BITS = mbcr_pkg::DEFAULT_VALUE_BITS,
    localparam int AREA_W    = $clog2(MAX_DIM * MAX_DIM + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_write_enable,
    input  logic [mbcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbcr_pkg::CFG_DATA_W-1:0]    cfg_write_data,
    // Cell stream
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [VALUE_BITS-1:0]              s_cell_value,
    // Result stream
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [AREA_W-1:0]                  m_best_area
);

    import mbcr_pkg::*;

    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIFF_W     = VALUE_BITS + AREA_W + 1;
    localparam int TAB_ADDR_W = 2 * DIM_W;
    localparam int TAB_DEPTH  = 1 << TAB_ADDR_W;
    localparam int DCOL_DEPTH = MAX_DIM + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mbcr_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] row_count_reg;
    logic [CFG_DATA_W-1:0] column_count_reg;
    logic [CNT_W-1:0]      row_pos_reg;
    logic [CNT_W-1:0]      col_pos_reg;

    // Cell being written
    logic [CNT_W-1:0]      cell_r_reg;
    logic [CNT_W-1:0]      cell_c_reg;
    logic [DIFF_W-1:0]     cell_d_reg;
    logic [DIFF_W-1:0]     rowsum_reg;

    // Search counters
    logic [CNT_W-1:0]      srch_rows_reg;
    logic [CNT_W-1:0]      srch_cols_reg;
    logic [CNT_W-1:0]      top_reg;
    logic [CNT_W-1:0]      bottom_reg;
    logic [CNT_W-1:0]      col_reg;
    logic [CNT_W-1:0]      left_reg;
    logic [CNT_W-1:0]      right_reg;
    logic [AREA_W-1:0]     best_reg;

    // Read pipeline tags
    logic                  tab_za_reg;
    logic                  tab_zb_reg;
    logic                  dv_reg;
    logic [CNT_W-1:0]      dcol_reg;
    logic                  pv_reg;
    logic [CNT_W-1:0]      pw_reg;

    // Output register
    logic                  m_valid_reg;
    logic [AREA_W-1:0]     m_best_area_reg;

    // ------------------------------------------------------------------
    // Effective grid size and current position
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;
    logic [CNT_W-1:0] cur_r;
    logic [CNT_W-1:0] cur_c;
    logic             cur_white;

    always_comb begin
        priority if (row_count_reg == '0) begin
            rows_eff = CNT_W'(1);
        end else if (int'(row_count_reg) > MAX_DIM) begin
            rows_eff = CNT_W'(MAX_DIM);
        end else begin
            rows_eff = CNT_W'(row_count_reg);
        end
        priority if (column_count_reg == '0) begin
            cols_eff = CNT_W'(1);
        end else if (int'(column_count_reg) > MAX_DIM) begin
            cols_eff = CNT_W'(MAX_DIM);
        end else begin
            cols_eff = CNT_W'(column_count_reg);
        end
    end

    // Color comes from the stored position, even where a stale position restarts the address at the origin
    assign cur_white = row_pos_reg[0] ^ col_pos_reg[0];

    always_comb begin
        if (row_pos_reg >= rows_eff || col_pos_reg >= cols_eff) begin
            cur_r = '0;
            cur_c = '0;
        end else begin
            cur_r = row_pos_reg;
            cur_c = col_pos_reg;
        end
    end

    logic [DIFF_W-1:0] cell_value_ext;
    logic [DIFF_W-1:0] cell_d_next;

    assign cell_value_ext = DIFF_W'(s_cell_value);
    assign cell_d_next    = cur_white ? cell_value_ext : ('0 - cell_value_ext);

    // ------------------------------------------------------------------
    // Step flags
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] cell_c_inc;
    logic [CNT_W-1:0] cell_r_inc;
    logic [CNT_W-1:0] top_inc;
    logic [CNT_W-1:0] left_inc;
    logic             cell_last;
    logic             diff_last;
    logic             pair_row_last;
    logic             pair_last;
    logic             band_row_last;
    logic             band_last;

    assign cell_c_inc    = cell_c_reg + 1'b1;
    assign cell_r_inc    = cell_r_reg + 1'b1;
    assign top_inc       = top_reg + 1'b1;
    assign left_inc      = left_reg + 1'b1;
    assign cell_last     = (cell_c_inc >= cols_eff) && (cell_r_inc >= rows_eff);
    assign diff_last     = (col_reg == srch_cols_reg);
    assign pair_row_last = (right_reg == srch_cols_reg);
    assign pair_last     = pair_row_last && (left_inc == srch_cols_reg);
    assign band_row_last = (bottom_reg == srch_rows_reg);
    assign band_last     = band_row_last && (top_inc == srch_rows_reg);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    logic out_load;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                state_next = cell_last ? ST_DIFF : ST_IDLE;
            end
            ST_DIFF: begin
                if (diff_last) begin
                    state_next = ST_DIFF_END;
                end
            end
            ST_DIFF_END: begin
                state_next = ST_PAIR;
            end
            ST_PAIR: begin
                if (pair_last) begin
                    state_next = ST_PAIR_END;
                end
            end
            ST_PAIR_END: begin
                state_next = band_last ? ST_DONE : ST_DIFF;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    logic tab_we;
    logic diff_issue;
    logic pair_issue;

    always_comb begin
        s_ready    = 1'b0;
        tab_we     = 1'b0;
        diff_issue = 1'b0;
        pair_issue = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:     s_ready    = 1'b1;
            ST_CELL:     tab_we     = 1'b1;
            ST_DIFF:     diff_issue = 1'b1;
            ST_DIFF_END: ;
            ST_PAIR:     pair_issue = 1'b1;
            ST_PAIR_END: ;
            ST_DONE:     out_load   = !m_valid_reg || m_ready;
            default:     ;
        endcase
    end

    logic cell_accept;
    assign cell_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Prefix table: entry (r, c) for r, c >= 1 sits at {r-1, c-1}
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      cur_r_dec;
    logic [CNT_W-1:0]      top_dec;
    logic [CNT_W-1:0]      bottom_dec;
    logic [CNT_W-1:0]      col_dec;
    logic [TAB_ADDR_W-1:0] tab_raddr_a;
    logic [TAB_ADDR_W-1:0] tab_raddr_b;
    logic [TAB_ADDR_W-1:0] tab_waddr;
    logic                  tab_za_next;
    logic                  tab_zb_next;
    logic [DIFF_W-1:0]     tab_rd_a;
    logic [DIFF_W-1:0]     tab_rd_b;
    logic [DIFF_W-1:0]     tab_val_a;
    logic [DIFF_W-1:0]     tab_val_b;
    logic [DIFF_W-1:0]     rowsum_new;
    logic [DIFF_W-1:0]     tab_wdata;

    assign cur_r_dec  = cur_r - 1'b1;
    assign top_dec    = top_reg - 1'b1;
    assign bottom_dec = bottom_reg - 1'b1;
    assign col_dec    = col_reg - 1'b1;

    // Port A reads the row above the next cell, or the band top during a sweep
    always_comb begin
        if (state_reg == ST_DIFF) begin
            tab_raddr_a = {top_dec[DIM_W-1:0], col_dec[DIM_W-1:0]};
            tab_za_next = (top_reg == '0) || (col_reg == '0);
            tab_zb_next = (col_reg == '0);
        end else begin
            tab_raddr_a = {cur_r_dec[DIM_W-1:0], cur_c[DIM_W-1:0]};
            tab_za_next = (cur_r == '0);
            tab_zb_next = 1'b1;
        end
    end

    assign tab_raddr_b = {bottom_dec[DIM_W-1:0], col_dec[DIM_W-1:0]};
    assign tab_waddr   = {cell_r_reg[DIM_W-1:0], cell_c_reg[DIM_W-1:0]};
    assign tab_val_a   = tab_za_reg ? '0 : tab_rd_a;
    assign tab_val_b   = tab_zb_reg ? '0 : tab_rd_b;
    assign rowsum_new  = ((cell_c_reg == '0) ? '0 : rowsum_reg) + cell_d_reg;
    assign tab_wdata   = tab_val_a + rowsum_new;

    mbcr_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (TAB_DEPTH)
    ) u_prefix_ram (
        .clk       (aclk),
        .wr_en     (tab_we),
        .wr_addr   (tab_waddr),
        .wr_data   (tab_wdata),
        .rd_addr_a (tab_raddr_a),
        .rd_addr_b (tab_raddr_b),
        .rd_data_a (tab_rd_a),
        .rd_data_b (tab_rd_b)
    );

    // ------------------------------------------------------------------
    // Band column differences and the shared pair unit
    // ------------------------------------------------------------------
    logic [DIFF_W-1:0]  dmem_wdata;
    logic [DIFF_W-1:0]  d_left;
    logic [DIFF_W-1:0]  d_right;
    logic [CNT_W-1:0]   height;
    logic [2*CNT_W-1:0] pair_prod;
    logic [AREA_W-1:0]  pair_area;
    logic               pair_better;

    assign dmem_wdata  = tab_val_b - tab_val_a;
    assign height      = bottom_reg - top_reg;
    assign pair_prod   = height * pw_reg;
    assign pair_area   = pair_prod[AREA_W-1:0];
    assign pair_better = pv_reg && (d_left == d_right) && (pair_area > best_reg);

    mbcr_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (DCOL_DEPTH)
    ) u_band_ram (
        .clk       (aclk),
        .wr_en     (dv_reg),
        .wr_addr   (dcol_reg),
        .wr_data   (dmem_wdata),
        .rd_addr_a (left_reg),
        .rd_addr_b (right_reg),
        .rd_data_a (d_left),
        .rd_data_b (d_right)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            row_count_reg    <= CFG_DATA_W'(1);
            column_count_reg <= CFG_DATA_W'(1);
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            srch_rows_reg    <= CNT_W'(1);
            srch_cols_reg    <= CNT_W'(1);
            top_reg          <= '0;
            bottom_reg       <= CNT_W'(1);
            col_reg          <= '0;
            left_reg         <= '0;
            right_reg        <= CNT_W'(1);
            best_reg         <= '0;
            dv_reg           <= 1'b0;
            pv_reg           <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            dv_reg    <= diff_issue;
            pv_reg    <= pair_issue;

            // Advance the grid position after each table write
            if (tab_we) begin
                if (cell_c_inc < cols_eff) begin
                    row_pos_reg <= cell_r_reg;
                    col_pos_reg <= cell_c_inc;
                end else if (cell_r_inc < rows_eff) begin
                    row_pos_reg <= cell_r_inc;
                    col_pos_reg <= '0;
                end else begin
                    row_pos_reg <= '0;
                    col_pos_reg <= '0;
                end
            end

            // Register writes drop any partial grid
            if (cfg_write_enable) begin
                if (cfg_index == CFG_ROW_COUNT) begin
                    row_count_reg <= cfg_write_data;
                    row_pos_reg   <= '0;
                    col_pos_reg   <= '0;
                end else if (cfg_index == CFG_COLUMN_COUNT) begin
                    column_count_reg <= cfg_write_data;
                    row_pos_reg      <= '0;
                    col_pos_reg      <= '0;
                end
            end

            // Start the search on the last cell's write
            if (tab_we && cell_last) begin
                srch_rows_reg <= rows_eff;
                srch_cols_reg <= cols_eff;
                top_reg       <= '0;
                bottom_reg    <= CNT_W'(1);
                col_reg       <= '0;
                best_reg      <= '0;
            end

            if (diff_issue && !diff_last) begin
                col_reg <= col_reg + 1'b1;
            end

            if (state_reg == ST_DIFF_END) begin
                left_reg  <= '0;
                right_reg <= CNT_W'(1);
            end

            if (pair_issue && !pair_last) begin
                if (pair_row_last) begin
                    left_reg  <= left_inc;
                    right_reg <= left_inc + 1'b1;
                end else begin
                    right_reg <= right_reg + 1'b1;
                end
            end

            // Move to the next row band
            if (state_reg == ST_PAIR_END && !band_last) begin
                col_reg <= '0;
                if (band_row_last) begin
                    top_reg    <= top_inc;
                    bottom_reg <= top_inc + 1'b1;
                end else begin
                    bottom_reg <= bottom_reg + 1'b1;
                end
            end

            if (pair_better) begin
                best_reg <= pair_area;
            end

            // Hold the result until the consumer takes the transfer
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        tab_za_reg <= tab_za_next;
        tab_zb_reg <= tab_zb_next;
        dcol_reg   <= col_reg;
        pw_reg     <= right_reg - left_reg;

        if (cell_accept) begin
            cell_r_reg <= cur_r;
            cell_c_reg <= cur_c;
            cell_d_reg <= cell_d_next;
        end

        if (tab_we) begin
            rowsum_reg <= rowsum_new;
        end

        if (out_load) begin
            m_best_area_reg <= best_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_best_area = m_best_area_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MBCR_ASSERT_IMPLIES(a_pair_order, aclk, aresetn, (state_reg == ST_PAIR), (left_reg < right_reg && right_reg <= srch_cols_reg), "column pair out of order or range")
    `MBCR_ASSERT_IMPLIES(a_band_order, aclk, aresetn, (state_reg == ST_DIFF), (top_reg < bottom_reg && bottom_reg <= srch_rows_reg && col_reg <= srch_cols_reg), "row band or sweep column out of range")
    `MBCR_ASSERT_IMPLIES(a_result_source, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_DONE), "result raised outside the end of a search")

endmodule

// File: design/mbcr_ram.sv
module mbcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read on both ports
    always_ff @(posedge clk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
